// ===== src/tssp_pkg.sv =====
// Shared widths, register indexes, state types and divider port structs of the sector planner.
package tssp_pkg;

   localparam int SEG_W      = 16;
   localparam int MAP_W      = 32;
   localparam int SKIP_W     = 5;
   localparam int SPH_W      = 13;
   localparam int SPC_W      = 3;
   localparam int RETRY_W    = 8;
   localparam int HEAD_W     = 16;
   localparam int CYL_W      = 12;
   localparam int FSEC_W     = 8;
   localparam int POS_W      = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [RETRY_W-1:0]   RETRY_MAX = 8'hFF;
   localparam logic [SPH_W-1:0]     SPH_RESET = 13'd600;
   localparam logic [SPC_W-1:0]     SPC_RESET = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SEGS_PER_HEAD     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGS_PER_CYLINDER = 1'b1;

   typedef enum logic [2:0] {
      MAIN_IDLE,
      MAIN_HEAD,
      MAIN_CYL,
      MAIN_WAIT,
      MAIN_OUT
   } main_state_type;

   typedef enum logic [1:0] {
      SCAN_SKIP,
      SCAN_LEAD,
      SCAN_RUN,
      SCAN_DONE
   } scan_state_type;

   typedef struct packed {
      logic             start;
      logic [SEG_W-1:0] dividend;
      logic [SPH_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [SEG_W-1:0] quotient;
      logic [SPH_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== src/tssp_req_if.sv =====
// Request channel of the sector planner: valid, ready and the segment request fields.
interface tssp_req_if;
   import tssp_pkg::*;

   logic              valid;
   logic              ready;
   logic [SEG_W-1:0]  segment_num;
   logic [MAP_W-1:0]  bad_map;
   logic              mode_writing;
   logic              skip_allowed;
   logic [SKIP_W-1:0] skip_sectors;

   modport source (
      output valid, segment_num, bad_map, mode_writing, skip_allowed, skip_sectors,
      input  ready
   );

   modport sink (
      input  valid, segment_num, bad_map, mode_writing, skip_allowed, skip_sectors,
      output ready
   );

endinterface

// ===== src/tssp_rsp_if.sv =====
// Result channel of the sector planner: valid, ready and the transfer plan fields.
interface tssp_rsp_if;
   import tssp_pkg::*;

   logic               valid;
   logic               ready;
   logic               is_retry;
   logic [RETRY_W-1:0] retry_count;
   logic [HEAD_W-1:0]  head_num;
   logic [CYL_W-1:0]   cylinder_num;
   logic [FSEC_W-1:0]  first_sector;
   logic [SKIP_W-1:0]  skip_span;
   logic [SKIP_W-1:0]  good_skipped;
   logic [MAP_W-1:0]   shifted_bad_map;
   logic [POS_W-1:0]   cluster_start;
   logic [POS_W-1:0]   cluster_len;
   logic [POS_W-1:0]   sectors_left;

   modport source (
      output valid, is_retry, retry_count, head_num, cylinder_num, first_sector,
             skip_span, good_skipped, shifted_bad_map, cluster_start, cluster_len,
             sectors_left,
      input  ready
   );

   modport sink (
      input  valid, is_retry, retry_count, head_num, cylinder_num, first_sector,
             skip_span, good_skipped, shifted_bad_map, cluster_start, cluster_len,
             sectors_left,
      output ready
   );

endinterface

// ===== src/tssp_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by the head and cylinder divisions.
module tssp_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  tssp_pkg::div_req_type div_req,
   output tssp_pkg::div_rsp_type div_rsp
);
   import tssp_pkg::*;

   localparam int CNT_W = $clog2(SEG_W);

   logic [SEG_W-1:0] quo_ff, quo_in;
   logic [SPH_W-1:0] rem_ff, rem_in;
   logic [SPH_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [SPH_W:0]   trial;
   logic [SPH_W:0]   diff;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[SEG_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      ge      = trial >= {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in = div_req.dividend;
         rem_in = '0;
         dsr_in = div_req.divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? diff[SPH_W-1:0] : trial[SPH_W-1:0];
         quo_in = {quo_ff[SEG_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SEG_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy      = run_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== src/tape_segment_sector_planner.sv =====
// Top level of the tape segment sector planner: retry tracking, geometry division, map scan.
//
// Requests arrive on req_if (valid/ready); each one yields exactly one result on rsp_if.
// A request repeating the previous segment in the same mode is a retry: the saturating
// retry count advances and, when allowed, the leading skip_sectors sectors are dropped.
// Head and cylinder come from two 16-step passes through one restoring divider, one
// quotient bit a cycle. The sector scan (skip count, leading bad sectors, first good
// run) walks one sector a cycle alongside the divider; the result is loaded once the
// divider passes, the scan and the segment modulo are all done.
// req_if.ready is high only while no request is in flight, so a request is accepted
// only after the previous one has been worked and its result loaded for output.
// The result sits in an output register until rsp_if.ready takes it; the next request is
// accepted and worked meanwhile, and its result waits if the register is still full.
// Reset clears the retry history, loads the geometry registers with 600 segments per
// head and 4 per cylinder, and empties the output register.
// csr_write_en writes csr_write_data into the register at csr_index; write only when idle.
// A zero geometry register divides as one.
module tape_segment_sector_planner #(
   parameter int SECTORS_PER_SEG = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   tssp_req_if.sink                          req_if,
   tssp_rsp_if.source                        rsp_if,
   input  logic                              csr_write_en,
   input  logic [tssp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tssp_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import tssp_pkg::*;

   localparam int                   N       = SECTORS_PER_SEG;
   localparam int                   SUM_W   = POS_W + 1;
   localparam int                   MCNT_W  = $clog2(SEG_W + 1);
   localparam logic [POS_W-1:0]     N_POS   = POS_W'(SECTORS_PER_SEG);
   localparam logic [POS_W-1:0]     MAX_OFF = POS_W'(SECTORS_PER_SEG - 1);
   localparam logic [N-1:0]         ALL_BAD = '1;
   localparam logic [MCNT_W-1:0]    MOD_END = MCNT_W'(SEG_W);

   main_state_type     main_state_ff, main_state_in;
   scan_state_type     scan_state_ff, scan_state_in;

   logic [SPH_W-1:0]   sph_ff, sph_in;
   logic [SPC_W-1:0]   spc_ff, spc_in;
   logic [SPH_W-1:0]   sph_eff;
   logic [SPC_W-1:0]   spc_eff;

   logic [SEG_W-1:0]   prev_segment_ff;
   logic               prev_valid_ff;
   logic               prev_mode_ff;
   logic [RETRY_W-1:0] retries_ff, retries_in;

   logic               req_accept;
   logic               retry_new;
   logic [SKIP_W-1:0]  offset_new;

   logic               retry_ff;
   logic [SKIP_W-1:0]  offset_ff;
   logic [SKIP_W-1:0]  skip_cnt_ff, skip_cnt_in;
   logic [SKIP_W-1:0]  data_off_ff, data_off_in;
   logic [N-1:0]       scratch_ff, scratch_in;
   logic [N-1:0]       run_map_ff, run_map_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   remain_ff, remain_in;
   logic [POS_W-1:0]   len_ff, len_in;

   logic [SEG_W-1:0]   mod_sh_ff, mod_sh_in;
   logic [SPC_W-1:0]   mod_ff, mod_in;
   logic [MCNT_W-1:0]  mod_cnt_ff, mod_cnt_in;
   logic [SPC_W:0]     mod_trial;
   logic [SPC_W:0]     mod_diff;
   logic               mod_done;

   logic [HEAD_W-1:0]  head_ff, head_in;
   logic [CYL_W-1:0]   cyl_ff, cyl_in;
   logic [FSEC_W-1:0]  first_sector;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic               load_out;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               o_is_retry_ff;
   logic [RETRY_W-1:0] o_retry_count_ff;
   logic [HEAD_W-1:0]  o_head_ff;
   logic [CYL_W-1:0]   o_cyl_ff;
   logic [FSEC_W-1:0]  o_first_sector_ff;
   logic [SKIP_W-1:0]  o_skip_span_ff;
   logic [SKIP_W-1:0]  o_good_skipped_ff;
   logic [MAP_W-1:0]   o_map_ff;
   logic [POS_W-1:0]   o_cluster_start_ff;
   logic [POS_W-1:0]   o_cluster_len_ff;
   logic [POS_W-1:0]   o_sectors_left_ff;

   tssp_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_if.ready = (main_state_ff == MAIN_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign sph_eff      = (sph_ff == '0) ? SPH_W'(1) : sph_ff;
   assign spc_eff      = (spc_ff == '0) ? SPC_W'(1) : spc_ff;

   // configuration registers
   always_comb begin
      sph_in = sph_ff;
      spc_in = spc_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SEGS_PER_HEAD:     sph_in = csr_write_data[SPH_W-1:0];
            CSR_SEGS_PER_CYLINDER: spc_in = csr_write_data[SPC_W-1:0];
         endcase
      end
   end

   // retry decision and skip offset
   always_comb begin
      retry_new  = prev_valid_ff && (req_if.mode_writing == prev_mode_ff) &&
                   (req_if.segment_num == prev_segment_ff);
      offset_new = '0;
      if (retry_new && req_if.skip_allowed && (req_if.skip_sectors != '0)) begin
         offset_new = (POS_W'(req_if.skip_sectors) > MAX_OFF) ?
                      MAX_OFF[SKIP_W-1:0] : req_if.skip_sectors;
      end
      retries_in = retries_ff;
      if (req_accept) begin
         if (!retry_new) begin
            retries_in = '0;
         end else if (retries_ff != RETRY_MAX) begin
            retries_in = retries_ff + 1'b1;
         end
      end
   end

   // segment modulo sectors per cylinder, one bit a cycle
   always_comb begin
      mod_trial  = {mod_ff, mod_sh_ff[SEG_W-1]};
      mod_diff   = mod_trial - {1'b0, spc_eff};
      mod_done   = (mod_cnt_ff == MOD_END);
      mod_sh_in  = mod_sh_ff;
      mod_in     = mod_ff;
      mod_cnt_in = mod_cnt_ff;
      if (req_accept) begin
         mod_sh_in  = req_if.segment_num;
         mod_in     = '0;
         mod_cnt_in = '0;
      end else if (!mod_done) begin
         mod_in     = (mod_trial >= {1'b0, spc_eff}) ? mod_diff[SPC_W-1:0] :
                      mod_trial[SPC_W-1:0];
         mod_sh_in  = {mod_sh_ff[SEG_W-2:0], 1'b0};
         mod_cnt_in = mod_cnt_ff + 1'b1;
      end
   end

   assign first_sector = FSEC_W'(mod_ff) * FSEC_W'(SECTORS_PER_SEG) + FSEC_W'(1);

   // sector scan
   always_comb begin
      scan_state_in = scan_state_ff;
      skip_cnt_in   = skip_cnt_ff;
      data_off_in   = data_off_ff;
      scratch_in    = scratch_ff;
      run_map_in    = run_map_ff;
      pos_in        = pos_ff;
      remain_in     = remain_ff;
      len_in        = len_ff;
      if (req_accept) begin
         scan_state_in = SCAN_SKIP;
         skip_cnt_in   = offset_new;
         data_off_in   = '0;
         scratch_in    = req_if.bad_map[N-1:0];
         run_map_in    = '0;
         pos_in        = POS_W'(offset_new);
         remain_in     = N_POS - POS_W'(offset_new);
         len_in        = '0;
      end else begin
         unique case (scan_state_ff)
            SCAN_SKIP: begin
               if (skip_cnt_ff != '0) begin
                  data_off_in = data_off_ff + SKIP_W'(!scratch_ff[0]);
                  scratch_in  = scratch_ff >> 1;
                  skip_cnt_in = skip_cnt_ff - 1'b1;
               end else begin
                  if (scratch_ff == ALL_BAD) begin
                     scratch_in[0] = 1'b0;
                  end
                  scan_state_in = SCAN_LEAD;
               end
            end
            SCAN_LEAD: begin
               if ((remain_ff != '0) && scratch_ff[0]) begin
                  scratch_in = scratch_ff >> 1;
                  pos_in     = pos_ff + 1'b1;
                  remain_in  = remain_ff - 1'b1;
               end else begin
                  run_map_in    = scratch_ff;
                  scan_state_in = SCAN_RUN;
               end
            end
            SCAN_RUN: begin
               if ((len_ff < remain_ff) && !run_map_ff[0]) begin
                  len_in     = len_ff + 1'b1;
                  run_map_in = run_map_ff >> 1;
               end else begin
                  scan_state_in = SCAN_DONE;
               end
            end
            SCAN_DONE: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      main_state_in = main_state_ff;
      div_req       = '{start: 1'b0, dividend: '0, divisor: '0};
      load_out      = 1'b0;
      head_in       = head_ff;
      cyl_in        = cyl_ff;
      unique case (main_state_ff)
         MAIN_IDLE: begin
            if (req_accept) begin
               div_req       = '{start: 1'b1, dividend: req_if.segment_num, divisor: sph_eff};
               main_state_in = MAIN_HEAD;
            end
         end
         MAIN_HEAD: begin
            if (div_rsp.done) begin
               head_in       = div_rsp.quotient;
               div_req       = '{start: 1'b1, dividend: SEG_W'(div_rsp.remainder),
                                 divisor: SPH_W'(spc_eff)};
               main_state_in = MAIN_CYL;
            end
         end
         MAIN_CYL: begin
            if (div_rsp.done) begin
               cyl_in        = div_rsp.quotient[CYL_W-1:0];
               main_state_in = MAIN_WAIT;
            end
         end
         MAIN_WAIT: begin
            if ((scan_state_ff == SCAN_DONE) && mod_done) begin
               main_state_in = MAIN_OUT;
            end
         end
         MAIN_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               load_out      = 1'b1;
               main_state_in = MAIN_IDLE;
            end
         end
         default: main_state_in = MAIN_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_state_ff   <= MAIN_IDLE;
         scan_state_ff   <= SCAN_DONE;
         sph_ff          <= SPH_RESET;
         spc_ff          <= SPC_RESET;
         prev_segment_ff <= '0;
         prev_valid_ff   <= 1'b0;
         prev_mode_ff    <= 1'b0;
         retries_ff      <= '0;
         mod_cnt_ff      <= MOD_END;
         rsp_valid_ff    <= 1'b0;
      end else begin
         main_state_ff   <= main_state_in;
         scan_state_ff   <= scan_state_in;
         sph_ff          <= sph_in;
         spc_ff          <= spc_in;
         retries_ff      <= retries_in;
         mod_cnt_ff      <= mod_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (req_accept) begin
            prev_segment_ff <= req_if.segment_num;
            prev_valid_ff   <= 1'b1;
            prev_mode_ff    <= req_if.mode_writing;
         end
      end
   end

   always_ff @(posedge clock) begin
      skip_cnt_ff <= skip_cnt_in;
      data_off_ff <= data_off_in;
      scratch_ff  <= scratch_in;
      run_map_ff  <= run_map_in;
      pos_ff      <= pos_in;
      remain_ff   <= remain_in;
      len_ff      <= len_in;
      mod_sh_ff   <= mod_sh_in;
      mod_ff      <= mod_in;
      head_ff     <= head_in;
      cyl_ff      <= cyl_in;
      if (req_accept) begin
         retry_ff  <= retry_new;
         offset_ff <= offset_new;
      end
      if (load_out) begin
         o_is_retry_ff      <= retry_ff;
         o_retry_count_ff   <= retries_ff;
         o_head_ff          <= head_ff;
         o_cyl_ff           <= cyl_ff;
         o_first_sector_ff  <= first_sector;
         o_skip_span_ff     <= offset_ff;
         o_good_skipped_ff  <= data_off_ff;
         o_map_ff           <= MAP_W'(scratch_ff);
         o_cluster_start_ff <= pos_ff;
         o_cluster_len_ff   <= len_ff;
         o_sectors_left_ff  <= remain_ff;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.is_retry        = o_is_retry_ff;
   assign rsp_if.retry_count     = o_retry_count_ff;
   assign rsp_if.head_num        = o_head_ff;
   assign rsp_if.cylinder_num    = o_cyl_ff;
   assign rsp_if.first_sector    = o_first_sector_ff;
   assign rsp_if.skip_span       = o_skip_span_ff;
   assign rsp_if.good_skipped    = o_good_skipped_ff;
   assign rsp_if.shifted_bad_map = o_map_ff;
   assign rsp_if.cluster_start   = o_cluster_start_ff;
   assign rsp_if.cluster_len     = o_cluster_len_ff;
   assign rsp_if.sectors_left    = o_sectors_left_ff;

   a_fresh_zero_retries: assert property (@(posedge clock) disable iff (reset)
      (load_out && !retry_ff) |-> (retries_ff == '0))
      else $error("fresh request leaves a nonzero retry count");

   a_pos_remain_sum: assert property (@(posedge clock) disable iff (reset)
      (main_state_ff != MAIN_IDLE) |-> (SUM_W'(pos_ff) + SUM_W'(remain_ff) == SUM_W'(N)))
      else $error("cluster start and sectors left do not span the segment");

   a_len_bounded: assert property (@(posedge clock) disable iff (reset)
      ((main_state_ff != MAIN_IDLE) && (scan_state_ff == SCAN_DONE)) |-> (len_ff <= remain_ff))
      else $error("cluster length runs past the segment end");

   a_data_off_bounded: assert property (@(posedge clock) disable iff (reset)
      (main_state_ff == MAIN_WAIT) |-> (data_off_ff <= offset_ff))
      else $error("good sector count exceeds the skipped sectors");

   a_idle_divider: assert property (@(posedge clock) disable iff (reset)
      (main_state_ff == MAIN_IDLE) |-> !div_rsp.busy)
      else $error("divider still running while ready for a request");

endmodule
